[sv/sddac_pkg.sv]
// ----------------------------------------------------------------------------
// sddac_pkg
// Shared constants, register codes and the sine table builder for the
// one-bit sigma-delta DAC.
// ----------------------------------------------------------------------------
package sddac_pkg;

  // Default configuration of the block
  localparam int unsigned OVERSAMPLE_DEF   = 4;
  localparam int unsigned FULL_SCALE_DEF   = 8192;
  localparam int unsigned SINE_ENTRIES_DEF = 1024;
  localparam int unsigned PHASE_BITS_DEF   = 24;

  // Fixed field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned STEP_W    = 24;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Mode codes (the fourth code is unused and leaves the pin low)
  localparam logic [MODE_W-1:0] MODE_TONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PCM    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SQUARE_STEP = 2'd2;

  // Register reset values
  localparam logic [MODE_W-1:0] MODE_RESET        = MODE_TONE;
  localparam logic [STEP_W-1:0] TONE_STEP_RESET   = 24'd349525;
  localparam logic [STEP_W-1:0] SQUARE_STEP_RESET = 24'd87381;

  // 2*pi in Q30
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

  // 20 in Q30, denominator of the 17/20 amplitude scale
  localparam logic [63:0] SINE_SCALE_DIV = 64'd20 << 30;

  // Table entry k: 0.85 * full_scale * sin(2*pi*k/entries), built from a
  // quadrant fold and an eight-term Taylor series in Q30. Evaluated only at
  // elaboration. frac_shift is 32 - log2(entries).
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(
    input int unsigned k,
    input int unsigned frac_shift,
    input int unsigned full_scale
  );
    logic [63:0]        f;
    logic [63:0]        q;
    logic [63:0]        a;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    logic               neg;
    f   = 64'(k) << frac_shift;
    q   = 64'd1 << 30;
    neg = 1'b0;
    if (f < q) begin
      a = f;
    end else if (f < 2 * q) begin
      a = 2 * q - f;
    end else if (f < 3 * q) begin
      a   = f - 2 * q;
      neg = 1'b1;
    end else begin
      a   = 4 * q - f;
      neg = 1'b1;
    end
    x    = (a * TWO_PI_Q30) >> 32;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 7; n++) begin
      term = (term * x2) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    v = (unsigned'(sum) * 64'(full_scale) * 64'd17) / SINE_SCALE_DIV;
    return neg ? signed'(-SAMPLE_W'(v)) : signed'(SAMPLE_W'(v));
  endfunction

endpackage

[sv/sigma_delta_one_bit_dac_unit.sv]
// ----------------------------------------------------------------------------
// sigma_delta_one_bit_dac_unit
// First-order one-bit sigma-delta DAC with sine tone, square and PCM modes.
// ----------------------------------------------------------------------------
//  channel  signals                                        direction
//  input    in_valid, in_stall, sample, sample_present,   tick in
//           regroup
//  output   out_valid, out_stall, pin_level,               level out
//           sample_missed
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data      register write
//
//  One tick per clock while out_stall holds no pending result; each tick's
//  result is registered and shows in the cycle after acceptance. The
//  integrator update (a three-term sum and a compare) sets the per-tick path.
//  The sine table is read ahead of use, addressed from the phase
//  the next group start will use.
//  rst clears all state but pin_level and sample_missed and loads the
//  register defaults; cfg_ready is always high.
//  A pending result held by out_stall stalls the input side only.
// ----------------------------------------------------------------------------
module sigma_delta_one_bit_dac_unit
  import sddac_pkg::*;
#(
  parameter int unsigned OVERSAMPLE   = OVERSAMPLE_DEF,
  parameter int unsigned FULL_SCALE   = FULL_SCALE_DEF,
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF,
  parameter int unsigned PHASE_BITS   = PHASE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic                        sample_present,
  input  logic                        regroup,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        pin_level,
  output logic                        sample_missed,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [STEP_W-1:0]           cfg_data
);

  localparam int unsigned GC_W  = $clog2(OVERSAMPLE);
  localparam int unsigned AW    = $clog2(SINE_ENTRIES);
  localparam int unsigned FS_W  = $clog2(FULL_SCALE) + 2;
  localparam int unsigned INT_W = $clog2(FULL_SCALE) + 3;
  localparam int unsigned PB    = PHASE_BITS;

  localparam logic [GC_W-1:0]         GC_LAST = GC_W'(OVERSAMPLE - 1);
  localparam logic signed [FS_W-1:0]  FS_S    = FS_W'(FULL_SCALE);
  localparam logic signed [INT_W-1:0] FS_I    = INT_W'(FULL_SCALE);
  localparam logic [PB-1:0]           QUARTER = PB'(1) << (PB - 2);

  // configuration
  logic [MODE_W-1:0] mode,        mode_next;
  logic [STEP_W-1:0] tone_step,   tone_step_next;
  logic [STEP_W-1:0] square_step, square_step_next;

  // state
  logic signed [INT_W-1:0]    integrator,   integrator_next;
  logic signed [SAMPLE_W-1:0] held_sample,  held_sample_next;
  logic [GC_W-1:0]            group_count,  group_count_next;
  logic [PB-1:0]              tone_phase,   tone_phase_next;
  logic [PB-1:0]              square_phase, square_phase_next;

  logic                       out_valid_next;
  logic                       pin_next;
  logic                       missed_next;

  logic                       accept;
  logic                       cfg_write;
  logic [GC_W-1:0]            gc_eff;
  logic [PB-1:0]              tone_sum;
  logic [PB-1:0]              square_quarter;
  logic [PB-1:0]              rom_phase;
  logic signed [SAMPLE_W-1:0] rom_data;
  logic signed [SAMPLE_W+FS_W-1:0] pcm_prod;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_comb begin
    mode_next        = mode;
    tone_step_next   = tone_step;
    square_step_next = square_step;
    if (cfg_write) begin
      case (cfg_index)
        REG_MODE:        mode_next        = cfg_data[MODE_W-1:0];
        REG_TONE_STEP:   tone_step_next   = cfg_data;
        REG_SQUARE_STEP: square_step_next = cfg_data;
        default: ;
      endcase
    end
  end

  assign gc_eff         = regroup ? '0 : group_count;
  assign tone_sum       = tone_phase + PB'(tone_step);
  assign square_quarter = square_phase + QUARTER;
  // floor(sample * FULL_SCALE / 32768)
  assign pcm_prod       = sample * FS_S;

  always_comb begin
    integrator_next   = integrator;
    held_sample_next  = held_sample;
    group_count_next  = group_count;
    tone_phase_next   = tone_phase;
    square_phase_next = square_phase;
    pin_next          = pin_level;
    missed_next       = sample_missed;
    out_valid_next    = out_valid & out_stall;
    if (accept) begin
      out_valid_next   = 1'b1;
      pin_next         = 1'b0;
      missed_next      = 1'b0;
      group_count_next = gc_eff;
      case (mode)
        MODE_SQUARE: begin
          pin_next          = square_quarter[PB-1];
          square_phase_next = square_phase + PB'(square_step);
        end
        MODE_TONE, MODE_PCM: begin
          if (gc_eff == '0) begin
            if (mode == MODE_TONE) begin
              tone_phase_next  = tone_sum;
              held_sample_next = rom_data;
            end else if (sample_present) begin
              held_sample_next = pcm_prod[15 +: SAMPLE_W];
            end else begin
              missed_next = 1'b1;
            end
          end
          group_count_next = (gc_eff == GC_LAST) ? '0 : gc_eff + 1'b1;
          pin_next         = integrator > 0;
          integrator_next  = integrator + INT_W'(held_sample_next)
                             - (pin_next ? FS_I : -FS_I);
        end
        default: ;
      endcase
    end
  end

  // Address the table from the phase the next group start will reach, so
  // the registered read is ready on the following tick.
  assign rom_phase = rst ? PB'(TONE_STEP_RESET)
                         : tone_phase_next + PB'(tone_step_next);

  sddac_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES),
    .FULL_SCALE   (FULL_SCALE)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_phase[PB-1 -: AW]),
    .data (rom_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_RESET;
      tone_step     <= TONE_STEP_RESET;
      square_step   <= SQUARE_STEP_RESET;
      integrator    <= '0;
      held_sample   <= '0;
      group_count   <= '0;
      tone_phase    <= '0;
      square_phase  <= '0;
      out_valid     <= 1'b0;
    end else begin
      mode          <= mode_next;
      tone_step     <= tone_step_next;
      square_step   <= square_step_next;
      integrator    <= integrator_next;
      held_sample   <= held_sample_next;
      group_count   <= group_count_next;
      tone_phase    <= tone_phase_next;
      square_phase  <= square_phase_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pin_level     <= pin_next;
    sample_missed <= missed_next;
  end

  a_group_range: assert property (@(posedge clk) disable iff (rst)
    group_count <= GC_LAST)
    else $error("group count out of range");

  a_miss_pcm_only: assert property (@(posedge clk) disable iff (rst)
    accept && mode != MODE_PCM |=> !sample_missed)
    else $error("sample miss flagged outside PCM mode");

  a_square_holds: assert property (@(posedge clk) disable iff (rst)
    accept && mode == MODE_SQUARE |=> $stable(integrator) && $stable(held_sample))
    else $error("square tick disturbed the modulator");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction gave no result");

  a_tone_phase_steps: assert property (@(posedge clk) disable iff (rst)
    accept && mode != MODE_TONE |=> $stable(tone_phase))
    else $error("tone phase moved outside tone mode");

endmodule

[sv/sddac_sine_rom.sv]
// ----------------------------------------------------------------------------
// sddac_sine_rom
// Sine lookup table with a registered read port.
// ----------------------------------------------------------------------------
module sddac_sine_rom
  import sddac_pkg::*;
#(
  parameter int unsigned SINE_ENTRIES = SINE_ENTRIES_DEF,
  parameter int unsigned FULL_SCALE   = FULL_SCALE_DEF
) (
  input  logic                              clk,
  input  logic [$clog2(SINE_ENTRIES)-1:0]   addr,
  output logic signed [SAMPLE_W-1:0]        data
);

  localparam int unsigned AW = $clog2(SINE_ENTRIES);

  logic signed [SAMPLE_W-1:0] rom [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    assign rom[k] = sine_entry(k, 32 - AW, FULL_SCALE);
  end

  always_ff @(posedge clk) begin
    data <= rom[addr];
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the one-bit sigma-delta DAC. A tick predictor
// tracks the integrator, held sample, group counter and both phases, and
// matches every level the block emits against it. Register settings change
// between phases once all expected levels are in. Both handshakes see
// random idle bursts.
// ----------------------------------------------------------------------------
import sddac_pkg::*;

localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
localparam logic [CFG_IDX_W-1:0] REG_NONE    = 2'd3;

typedef struct packed {
  logic pin;
  logic missed;
} level_t;

class dac_tick_board;
  logic [MODE_W-1:0]          mode;
  logic [STEP_W-1:0]          tone_step;
  logic [STEP_W-1:0]          square_step;
  logic signed [SAMPLE_W-1:0] integ;
  logic signed [SAMPLE_W-1:0] held;
  logic [1:0]                 grp;
  logic [STEP_W-1:0]          tone_phase;
  logic [STEP_W-1:0]          square_phase;
  logic signed [SAMPLE_W-1:0] sine_rom [SINE_ENTRIES_DEF];
  level_t                     levels_due [$];
  int unsigned                errors;

  function new();
    for (int k = 0; k < SINE_ENTRIES_DEF; k++) sine_rom[k] = sine_value(k);
    mode         = MODE_RESET;
    tone_step    = TONE_STEP_RESET;
    square_step  = SQUARE_STEP_RESET;
    integ        = '0;
    held         = '0;
    grp          = '0;
    tone_phase   = '0;
    square_phase = '0;
    errors       = 0;
  endfunction

  // 0.85 * full scale * sin, quadrant fold then Taylor series in Q30
  function automatic logic signed [SAMPLE_W-1:0] sine_value(int unsigned k);
    logic [63:0]    frac;
    logic [63:0]    ang;
    logic [63:0]    x;
    logic [63:0]    x2;
    logic [63:0]    t;
    logic [63:0]    mag;
    longint signed  acc;
    logic           neg;
    frac = (64'(k) << 32) / 64'(SINE_ENTRIES_DEF);
    neg  = frac[31];
    case (frac[31:30])
      2'd0:    ang = frac;
      2'd1:    ang = (64'd1 << 31) - frac;
      2'd2:    ang = frac - (64'd1 << 31);
      default: ang = (64'd1 << 32) - frac;
    endcase
    x   = (ang * 64'd6746518852) >> 32;
    x2  = (x * x) >> 30;
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    mag = (64'(acc) * 64'(FULL_SCALE_DEF) * 64'd17) / (64'd20 << 30);
    return neg ? -$signed(mag[SAMPLE_W-1:0]) : $signed(mag[SAMPLE_W-1:0]);
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [STEP_W-1:0] data);
    case (idx)
      REG_MODE:        mode        = data[MODE_W-1:0];
      REG_TONE_STEP:   tone_step   = data;
      REG_SQUARE_STEP: square_step = data;
      default: ;
    endcase
  endfunction

  function void note_tick(logic signed [SAMPLE_W-1:0] s, logic present, logic rg);
    level_t           lv;
    logic [STEP_W-1:0] shifted;
    int               acc;
    lv = '0;
    if (rg) grp = '0;
    case (mode)
      MODE_SQUARE: begin
        shifted      = square_phase + (24'd1 << (STEP_W - 2));
        lv.pin       = shifted[STEP_W-1];
        square_phase = square_phase + square_step;
      end
      MODE_TONE, MODE_PCM: begin
        if (grp == 2'd0) begin
          if (mode == MODE_TONE) begin
            tone_phase = tone_phase + tone_step;
            held       = sine_rom[tone_phase[STEP_W-1 -: 10]];
          end else if (present) begin
            held = s >>> 2;
          end else begin
            lv.missed = 1'b1;
          end
        end
        grp    = grp + 2'd1;
        lv.pin = (integ > 0);
        acc    = int'(integ) + int'(held) +
                 (lv.pin ? -int'(FULL_SCALE_DEF) : int'(FULL_SCALE_DEF));
        integ  = acc[SAMPLE_W-1:0];
      end
      default: ;
    endcase
    levels_due.push_back(lv);
  endfunction

  function void check_result(logic pin, logic missed);
    level_t lv;
    if (levels_due.size() == 0) begin
      $error("level emitted with none expected");
      errors++;
      return;
    end
    lv = levels_due.pop_front();
    if (pin !== lv.pin) begin
      $error("pin_level: expected %0d, got %0d", lv.pin, pin);
      errors++;
    end
    if (missed !== lv.missed) begin
      $error("sample_missed: expected %0d, got %0d", lv.missed, missed);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return levels_due.size();
  endfunction
endclass

module tb_top;
  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       sample_present = 1'b0;
  logic                       regroup = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       pin_level;
  logic                       sample_missed;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [STEP_W-1:0]          cfg_data = '0;

  dac_tick_board board = new();
  logic          calm = 1'b0;
  int unsigned   fed = 0;
  logic [MODE_W-1:0] cur_mode = MODE_RESET;

  sigma_delta_one_bit_dac_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .sample_present (sample_present),
    .regroup        (regroup),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pin_level      (pin_level),
    .sample_missed  (sample_missed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_tick(sample, sample_present, regroup);
      if (out_valid && !out_stall) board.check_result(pin_level, sample_missed);
      if (cfg_valid && cfg_ready) board.set_reg(cfg_index, cfg_data);
    end
  end

  // receiver back-pressure in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 6) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // called and returns at a falling edge; valid stays high for back-to-back ticks
  task automatic feed_tick(input logic signed [SAMPLE_W-1:0] s, input logic p,
                           input logic rg);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample         = s;
    sample_present = p;
    regroup        = rg;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
    fed++;
  endtask

  // only once every expected level is in
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    in_valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_MODE) cur_mode = data[MODE_W-1:0];
    @(negedge clk);
  endtask

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return STEP_W'($urandom_range(1, 4096));
      3:       return STEP_W'(1) << $urandom_range(0, STEP_W - 1);
      default: return STEP_W'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    logic                       p;
    logic                       rg;
    logic [MODE_W-1:0]          m;
    int unsigned                ticks;
    int unsigned                waited;
    int unsigned                sel;

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // reset settings: tone mode
    feed_tick(16'sd0, 1'b1, 1'b1);
    feed_tick(16'sh7fff, 1'b0, 1'b0);
    feed_tick(16'sh8000, 1'b1, 1'b0);
    feed_tick(16'sd0, 1'b0, 1'b0);
    feed_tick(16'sd0, 1'b0, 1'b0);

    // PCM: full-scale samples, a miss, regroup on a miss and on a hit
    write_reg(REG_MODE, STEP_W'(MODE_PCM));
    feed_tick(16'sh7fff, 1'b1, 1'b1);
    feed_tick(16'sh8000, 1'b1, 1'b0);
    feed_tick(16'sd1, 1'b0, 1'b0);
    feed_tick(-16'sd1, 1'b1, 1'b0);
    feed_tick(16'sh8000, 1'b1, 1'b0);
    feed_tick(16'sd0, 1'b0, 1'b0);
    feed_tick(16'sd0, 1'b0, 1'b1);
    feed_tick(-16'sd1, 1'b1, 1'b1);

    write_reg(REG_SQUARE_STEP, 24'h3fffff);
    write_reg(REG_MODE, STEP_W'(MODE_SQUARE));
    feed_tick(16'sd0, 1'b1, 1'b0);
    feed_tick(16'sh7fff, 1'b0, 1'b1);
    feed_tick(16'sh8000, 1'b1, 1'b0);

    write_reg(REG_MODE, STEP_W'(MODE_UNUSED));
    feed_tick(16'sh7fff, 1'b1, 1'b1);
    feed_tick(16'sh8000, 1'b0, 1'b0);

    // tone with the largest step wraps the phase every group
    write_reg(REG_TONE_STEP, 24'hffffff);
    write_reg(REG_MODE, STEP_W'(MODE_TONE));
    feed_tick(16'sd0, 1'b0, 1'b0);
    feed_tick(16'sd0, 1'b1, 1'b1);
    feed_tick(16'sd0, 1'b0, 1'b0);
    feed_tick(16'sd0, 1'b1, 1'b0);
    write_reg(REG_NONE, STEP_W'($urandom));

    while (fed < 1250) begin
      sel = $urandom_range(0, 9);
      if (sel < 3) m = MODE_TONE;
      else if (sel < 5) m = MODE_SQUARE;
      else if (sel < 9) m = MODE_PCM;
      else m = MODE_UNUSED;
      // upper data bits of the mode write are don't-care
      write_reg(REG_MODE, {(STEP_W - MODE_W)'($urandom), m});
      if ($urandom_range(0, 9) < 6) write_reg(REG_TONE_STEP, pick_step());
      if ($urandom_range(0, 9) < 6) write_reg(REG_SQUARE_STEP, pick_step());
      if ($urandom_range(0, 15) == 0) write_reg(REG_NONE, STEP_W'($urandom));
      ticks = $urandom_range(40, 120);
      repeat (ticks) begin
        if (fed >= 1100) calm = 1'b1;
        case ($urandom_range(0, 9))
          0:       s = 16'sh8000;
          1:       s = 16'sh7fff;
          2:       s = $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
          default: s = SAMPLE_W'($urandom);
        endcase
        if (cur_mode == MODE_PCM) p = ($urandom_range(0, 9) != 0);
        else p = 1'($urandom_range(0, 1));
        rg = ($urandom_range(0, 15) == 0);
        feed_tick(s, p, rg);
      end
    end

    in_valid = 1'b0;
    waited   = 0;
    while (board.pending() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (board.pending() != 0) begin
      $error("%0d expected levels never arrived", board.pending());
      board.errors++;
    end

    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

[files.f]
sv/sddac_pkg.sv
sv/sddac_sine_rom.sv
sv/sigma_delta_one_bit_dac_unit.sv
bench/tb_top.sv
